[src/closest_point_on_segment_assert.svh]
// assertion macros for the closest point block
`ifndef CLOSEST_POINT_ON_SEGMENT_ASSERT_SVH
`define CLOSEST_POINT_ON_SEGMENT_ASSERT_SVH

// checked outside reset
`define CPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// checked on every edge, reset included
`define CPS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

[src/cps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cps_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int NUM_W      = PROD_W;
    localparam int DEN_W      = 2 * COORD_BITS + 1;
    localparam int NMAG_W     = 2 * COORD_BITS + 1;
    localparam int P_W        = COORD_BITS + NMAG_W;
    localparam int N_W        = P_W + 2;
    localparam int D_W        = DEN_W + 1;
    localparam int Q_W        = COORD_BITS + 2;
    localparam int SUM_W      = Q_W + 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [NUM_W-1:0]      num_t;
    typedef logic [DEN_W-1:0]             den_t;
    typedef logic signed [SUM_W-1:0]      sum_t;
    typedef logic [1:0]                   mode_t;
    typedef logic [1:0]                   status_t;

    localparam mode_t MODE_CALC  = 2'd0;
    localparam mode_t MODE_START = 2'd1;
    localparam mode_t MODE_END   = 2'd2;
    localparam mode_t MODE_DEGEN = 2'd3;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_CLAMP = 2'd1;
    localparam status_t ST_SAT   = 2'd2;
    localparam status_t ST_DEGEN = 2'd3;

    localparam sum_t SAT_HI = {{(SUM_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam sum_t SAT_LO = {{(SUM_W-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

    typedef struct packed {
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        logic   clamp;
        diff_t  dx;
        diff_t  dy;
        num_t   num;
        den_t   den;
    } dot_t;

    typedef struct packed {
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        logic   neg_x;
        logic   neg_y;
        mode_t  mode;
    } side_t;

    typedef struct packed {
        side_t          side;
        logic [N_W-1:0] nx;
        logic [N_W-1:0] ny;
        logic [D_W-1:0] dd;
    } div_in_t;

    typedef struct packed {
        side_t          side;
        logic [Q_W-1:0] qx;
        logic [Q_W-1:0] qy;
    } div_out_t;

endpackage

`default_nettype wire

[src/cps_dot.sv]
`timescale 1ns / 1ps
`default_nettype none

module cps_dot
    import cps_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire coord_t in_sx,
    input  wire coord_t in_sy,
    input  wire coord_t in_ex,
    input  wire coord_t in_ey,
    input  wire coord_t in_qx,
    input  wire coord_t in_qy,
    input  wire logic   in_clamp,
    output logic        out_valid,
    input  wire logic   out_ready,
    output dot_t        out_data
);

    logic en_a, en_b, en_c;

    // stage a: differences
    logic   a_valid_reg;
    coord_t a_sx_reg, a_sy_reg, a_ex_reg, a_ey_reg;
    logic   a_clamp_reg;
    diff_t  a_dx_reg, a_dy_reg, a_vx_reg, a_vy_reg;

    // stage b: products
    logic   b_valid_reg;
    coord_t b_sx_reg, b_sy_reg, b_ex_reg, b_ey_reg;
    logic   b_clamp_reg;
    diff_t  b_dx_reg, b_dy_reg;
    prod_t  b_pvx_reg, b_pvy_reg, b_pdx_reg, b_pdy_reg;

    // stage c: dot products
    logic   c_valid_reg;
    dot_t   c_data_reg;
    dot_t   c_data_next;
    prod_t  den_sum;

    assign en_c      = !c_valid_reg || out_ready;
    assign en_b      = !b_valid_reg || en_c;
    assign en_a      = !a_valid_reg || en_b;
    assign in_ready  = en_a;
    assign out_valid = c_valid_reg;
    assign out_data  = c_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (en_a) begin
                a_valid_reg <= in_valid;
            end
            if (en_b) begin
                b_valid_reg <= a_valid_reg;
            end
            if (en_c) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            a_sx_reg    <= in_sx;
            a_sy_reg    <= in_sy;
            a_ex_reg    <= in_ex;
            a_ey_reg    <= in_ey;
            a_clamp_reg <= in_clamp;
            a_dx_reg    <= diff_t'(in_ex) - diff_t'(in_sx);
            a_dy_reg    <= diff_t'(in_ey) - diff_t'(in_sy);
            a_vx_reg    <= diff_t'(in_qx) - diff_t'(in_sx);
            a_vy_reg    <= diff_t'(in_qy) - diff_t'(in_sy);
        end
    end

    always_ff @(posedge aclk) begin
        if (en_b) begin
            b_sx_reg    <= a_sx_reg;
            b_sy_reg    <= a_sy_reg;
            b_ex_reg    <= a_ex_reg;
            b_ey_reg    <= a_ey_reg;
            b_clamp_reg <= a_clamp_reg;
            b_dx_reg    <= a_dx_reg;
            b_dy_reg    <= a_dy_reg;
            b_pvx_reg   <= prod_t'(a_vx_reg) * prod_t'(a_dx_reg);
            b_pvy_reg   <= prod_t'(a_vy_reg) * prod_t'(a_dy_reg);
            b_pdx_reg   <= prod_t'(a_dx_reg) * prod_t'(a_dx_reg);
            b_pdy_reg   <= prod_t'(a_dy_reg) * prod_t'(a_dy_reg);
        end
    end

    always_comb begin
        den_sum           = b_pdx_reg + b_pdy_reg;
        c_data_next.sx    = b_sx_reg;
        c_data_next.sy    = b_sy_reg;
        c_data_next.ex    = b_ex_reg;
        c_data_next.ey    = b_ey_reg;
        c_data_next.clamp = b_clamp_reg;
        c_data_next.dx    = b_dx_reg;
        c_data_next.dy    = b_dy_reg;
        c_data_next.num   = b_pvx_reg + b_pvy_reg;
        c_data_next.den   = den_sum[DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en_c) begin
            c_data_reg <= c_data_next;
        end
    end

endmodule

`default_nettype wire

[src/cps_scale.sv]
`timescale 1ns / 1ps
`default_nettype none

module cps_scale
    import cps_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire dot_t in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output div_in_t   out_data
);

    logic en_d, en_e;

    logic             d_valid_reg;
    side_t            d_side_reg;
    side_t            d_side_next;
    logic [P_W-1:0]   d_px_reg, d_py_reg;
    den_t             d_den_reg;

    logic             e_valid_reg;
    div_in_t          e_data_reg;

    diff_t            ndx, ndy;
    num_t             nnum;
    logic [COORD_BITS-1:0] mag_dx, mag_dy;
    logic [NMAG_W-1:0]     mag_num;
    logic             num_neg;

    assign en_e      = !e_valid_reg || out_ready;
    assign en_d      = !d_valid_reg || en_e;
    assign in_ready  = en_d;
    assign out_valid = e_valid_reg;
    assign out_data  = e_data_reg;

    always_comb begin
        ndx     = -in_data.dx;
        ndy     = -in_data.dy;
        nnum    = -in_data.num;
        num_neg = in_data.num[NUM_W-1];
        mag_dx  = in_data.dx[DIFF_W-1] ? ndx[COORD_BITS-1:0] : in_data.dx[COORD_BITS-1:0];
        mag_dy  = in_data.dy[DIFF_W-1] ? ndy[COORD_BITS-1:0] : in_data.dy[COORD_BITS-1:0];
        mag_num = num_neg ? nnum[NMAG_W-1:0] : in_data.num[NMAG_W-1:0];

        d_side_next.sx    = in_data.sx;
        d_side_next.sy    = in_data.sy;
        d_side_next.ex    = in_data.ex;
        d_side_next.ey    = in_data.ey;
        d_side_next.neg_x = in_data.dx[DIFF_W-1] ^ num_neg;
        d_side_next.neg_y = in_data.dy[DIFF_W-1] ^ num_neg;
        priority if (in_data.den == '0) begin
            d_side_next.mode = MODE_DEGEN;
        end else if (in_data.clamp && (num_neg || in_data.num == '0)) begin
            d_side_next.mode = MODE_START;
        end else if (in_data.clamp && (in_data.num > $signed({1'b0, in_data.den}))) begin
            d_side_next.mode = MODE_END;
        end else begin
            d_side_next.mode = MODE_CALC;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end else begin
            if (en_d) begin
                d_valid_reg <= in_valid;
            end
            if (en_e) begin
                e_valid_reg <= d_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_d) begin
            d_side_reg <= d_side_next;
            d_px_reg   <= P_W'(mag_dx) * P_W'(mag_num);
            d_py_reg   <= P_W'(mag_dy) * P_W'(mag_num);
            d_den_reg  <= in_data.den;
        end
    end

    // rounded quotient: (2p + den) / (2den)
    always_ff @(posedge aclk) begin
        if (en_e) begin
            e_data_reg.side <= d_side_reg;
            e_data_reg.nx   <= N_W'({d_px_reg, 1'b0}) + N_W'(d_den_reg);
            e_data_reg.ny   <= N_W'({d_py_reg, 1'b0}) + N_W'(d_den_reg);
            e_data_reg.dd   <= {d_den_reg, 1'b0};
        end
    end

endmodule

`default_nettype wire

[src/cps_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module cps_div
    import cps_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire div_in_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output div_out_t     out_data
);

    logic [Q_W-1:0] en;
    logic [Q_W-1:0] valid_reg;
    side_t          side_reg [Q_W];
    logic [Q_W-1:0] qx_reg   [Q_W];
    logic [Q_W-1:0] qy_reg   [Q_W];
    logic [D_W-1:0] dd_reg   [Q_W];
    logic [N_W-1:0] rx_reg   [Q_W-1];
    logic [N_W-1:0] ry_reg   [Q_W-1];

    assign in_ready        = en[0];
    assign out_valid       = valid_reg[Q_W-1];
    assign out_data.side   = side_reg[Q_W-1];
    assign out_data.qx     = qx_reg[Q_W-1];
    assign out_data.qy     = qy_reg[Q_W-1];

    // one quotient bit per stage, msb first
    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        localparam int BIT = Q_W - 1 - k;

        logic           v_in;
        side_t          side_in;
        logic [N_W-1:0] rx_in, ry_in, rx_sh, ry_sh, rx_next, ry_next;
        logic [Q_W-1:0] qx_in, qy_in, qx_next, qy_next;
        logic [D_W-1:0] dd_in;
        logic           take_x, take_y;

        if (k == Q_W - 1) begin : g_last
            assign en[k] = !valid_reg[k] || out_ready;
        end else begin : g_mid
            assign en[k] = !valid_reg[k] || en[k+1];
        end

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign side_in = in_data.side;
            assign rx_in   = in_data.nx;
            assign ry_in   = in_data.ny;
            assign qx_in   = '0;
            assign qy_in   = '0;
            assign dd_in   = in_data.dd;
        end else begin : g_rest
            assign v_in    = valid_reg[k-1];
            assign side_in = side_reg[k-1];
            assign rx_in   = rx_reg[k-1];
            assign ry_in   = ry_reg[k-1];
            assign qx_in   = qx_reg[k-1];
            assign qy_in   = qy_reg[k-1];
            assign dd_in   = dd_reg[k-1];
        end

        always_comb begin
            rx_sh   = rx_in >> BIT;
            ry_sh   = ry_in >> BIT;
            take_x  = rx_sh >= N_W'(dd_in);
            take_y  = ry_sh >= N_W'(dd_in);
            rx_next = take_x ? rx_in - (N_W'(dd_in) << BIT) : rx_in;
            ry_next = take_y ? ry_in - (N_W'(dd_in) << BIT) : ry_in;
            qx_next = qx_in | (take_x ? (Q_W'(1) << BIT) : '0);
            qy_next = qy_in | (take_y ? (Q_W'(1) << BIT) : '0);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en[k]) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                side_reg[k] <= side_in;
                qx_reg[k]   <= qx_next;
                qy_reg[k]   <= qy_next;
                dd_reg[k]   <= dd_in;
            end
        end

        if (k < Q_W - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en[k]) begin
                    rx_reg[k] <= rx_next;
                    ry_reg[k] <= ry_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

[src/cps_out.sv]
`timescale 1ns / 1ps
`default_nettype none

module cps_out
    import cps_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire div_out_t in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output coord_t        out_x,
    output coord_t        out_y,
    output status_t       out_status
);

    logic    en;
    logic    valid_reg;
    coord_t  x_reg, y_reg, x_next, y_next;
    status_t status_reg, status_next;

    sum_t    mag_x, mag_y, off_x, off_y, sum_x, sum_y;
    coord_t  sat_x, sat_y;
    logic    over_x, over_y;

    assign en         = !valid_reg || out_ready;
    assign in_ready   = en;
    assign out_valid  = valid_reg;
    assign out_x      = x_reg;
    assign out_y      = y_reg;
    assign out_status = status_reg;

    always_comb begin
        mag_x  = $signed({2'b00, in_data.qx});
        mag_y  = $signed({2'b00, in_data.qy});
        off_x  = in_data.side.neg_x ? -mag_x : mag_x;
        off_y  = in_data.side.neg_y ? -mag_y : mag_y;
        sum_x  = sum_t'(in_data.side.sx) + off_x;
        sum_y  = sum_t'(in_data.side.sy) + off_y;
        over_x = (sum_x > SAT_HI) || (sum_x < SAT_LO);
        over_y = (sum_y > SAT_HI) || (sum_y < SAT_LO);

        priority if (sum_x > SAT_HI) begin
            sat_x = SAT_HI[COORD_BITS-1:0];
        end else if (sum_x < SAT_LO) begin
            sat_x = SAT_LO[COORD_BITS-1:0];
        end else begin
            sat_x = sum_x[COORD_BITS-1:0];
        end

        priority if (sum_y > SAT_HI) begin
            sat_y = SAT_HI[COORD_BITS-1:0];
        end else if (sum_y < SAT_LO) begin
            sat_y = SAT_LO[COORD_BITS-1:0];
        end else begin
            sat_y = sum_y[COORD_BITS-1:0];
        end

        unique case (in_data.side.mode)
            MODE_DEGEN: begin
                x_next      = in_data.side.sx;
                y_next      = in_data.side.sy;
                status_next = ST_DEGEN;
            end
            MODE_START: begin
                x_next      = in_data.side.sx;
                y_next      = in_data.side.sy;
                status_next = ST_CLAMP;
            end
            MODE_END: begin
                x_next      = in_data.side.ex;
                y_next      = in_data.side.ey;
                status_next = ST_CLAMP;
            end
            default: begin
                x_next      = sat_x;
                y_next      = sat_y;
                status_next = (over_x || over_y) ? ST_SAT : ST_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg      <= x_next;
            y_reg      <= y_next;
            status_reg <= status_next;
        end
    end

endmodule

`default_nettype wire

[src/closest_point_on_segment.sv]
// closest point on a 2d segment or line, signed q8.8 coordinates
// pipeline: 3 dot product stages, 2 scaling stages, 18 divider stages of one
//   quotient bit each, 1 output stage
// throughput: one beat per cycle while m_ready is high; every stage, the divider included, is pipelined
// reset: synchronous active-low aresetn empties every stage; no beat is held over
`timescale 1ns / 1ps
`default_nettype none

module closest_point_on_segment
    import cps_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire coord_t  s_start_x,
    input  wire coord_t  s_start_y,
    input  wire coord_t  s_end_x,
    input  wire coord_t  s_end_y,
    input  wire coord_t  s_query_x,
    input  wire coord_t  s_query_y,
    input  wire logic    s_clamp_to_segment,
    output logic         m_valid,
    input  wire logic    m_ready,
    output coord_t       m_near_x,
    output coord_t       m_near_y,
    output status_t      m_status
);

    logic     dot_valid, dot_ready;
    dot_t     dot_data;
    logic     scl_valid, scl_ready;
    div_in_t  scl_data;
    logic     div_valid, div_ready;
    div_out_t div_data;

    cps_dot u_dot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_sx     (s_start_x),
        .in_sy     (s_start_y),
        .in_ex     (s_end_x),
        .in_ey     (s_end_y),
        .in_qx     (s_query_x),
        .in_qy     (s_query_y),
        .in_clamp  (s_clamp_to_segment),
        .out_valid (dot_valid),
        .out_ready (dot_ready),
        .out_data  (dot_data)
    );

    cps_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dot_valid),
        .in_ready  (dot_ready),
        .in_data   (dot_data),
        .out_valid (scl_valid),
        .out_ready (scl_ready),
        .out_data  (scl_data)
    );

    cps_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (scl_valid),
        .in_ready  (scl_ready),
        .in_data   (scl_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    cps_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (div_valid),
        .in_ready   (div_ready),
        .in_data    (div_data),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_x      (m_near_x),
        .out_y      (m_near_y),
        .out_status (m_status)
    );

endmodule

`default_nettype wire

[src/cps_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "closest_point_on_segment_assert.svh"

module cps_chk
    import cps_pkg::*;
(
    input wire logic    aclk,
    input wire logic    aresetn,
    input wire logic    s_ready,
    input wire logic    m_valid,
    input wire logic    m_ready,
    input wire coord_t  m_near_x,
    input wire coord_t  m_near_y,
    input wire status_t m_status
);

    `CPS_ASSERT(a_hold_valid, m_valid && !m_ready |=> m_valid, "result beat dropped while stalled")
    `CPS_ASSERT(a_hold_data, m_valid && !m_ready |=> $stable(m_near_x) && $stable(m_near_y) && $stable(m_status), "result beat changed while stalled")
    `CPS_ASSERT(a_flow, !m_valid || m_ready |-> s_ready, "input blocked while output drains")
    `CPS_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result beat after reset")

endmodule

bind closest_point_on_segment cps_chk u_cps_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_near_x (m_near_x),
    .m_near_y (m_near_y),
    .m_status (m_status)
);

`default_nettype wire

[bench/closest_point_on_segment_tb.sv]
`timescale 1ns / 1ps

module closest_point_on_segment_tb
    import cps_pkg::*;
();

    localparam int     RANDOM_ITEMS = 1930;
    localparam int     QUIET_LIMIT  = 4000;
    localparam int     DRAIN_CYCLES = 40;
    localparam longint COORD_MAX    = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN    = -COORD_MAX - 1;

    typedef struct {
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        coord_t qx;
        coord_t qy;
        logic   clamp;
    } query_t;

    typedef struct {
        coord_t  near_x;
        coord_t  near_y;
        status_t status;
    } near_point_t;

    logic    aclk = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    wire     s_ready;
    coord_t  s_start_x = '0;
    coord_t  s_start_y = '0;
    coord_t  s_end_x = '0;
    coord_t  s_end_y = '0;
    coord_t  s_query_x = '0;
    coord_t  s_query_y = '0;
    logic    s_clamp_to_segment = 1'b0;
    wire     m_valid;
    logic    m_ready = 1'b0;
    coord_t  m_near_x;
    coord_t  m_near_y;
    status_t m_status;

    query_t      query_q[$];
    near_point_t near_point_q[$];
    query_t      next_query;
    near_point_t want;
    int unsigned beats_in = 0;
    int unsigned beats_out = 0;
    int unsigned quiet_cycles = 0;
    int unsigned mismatches = 0;

    closest_point_on_segment dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_start_x         (s_start_x),
        .s_start_y         (s_start_y),
        .s_end_x           (s_end_x),
        .s_end_y           (s_end_y),
        .s_query_x         (s_query_x),
        .s_query_y         (s_query_y),
        .s_clamp_to_segment(s_clamp_to_segment),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_near_x          (m_near_x),
        .m_near_y          (m_near_y),
        .m_status          (m_status)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // round(d * num / den), ties away from zero, den > 0
    function automatic longint share_of(longint d, longint num, longint den);
        longint unsigned p;
        longint unsigned q;
        p = longint'(d < 0 ? -d : d) * longint'(num < 0 ? -num : num);
        q = (2 * p + longint'(den)) / (2 * longint'(den));
        return ((d < 0) != (num < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic coord_t clip_coord(longint v, inout logic ovf);
        if (v > COORD_MAX) begin
            ovf = 1'b1;
            return coord_t'(COORD_MAX);
        end
        if (v < COORD_MIN) begin
            ovf = 1'b1;
            return coord_t'(COORD_MIN);
        end
        return coord_t'(v);
    endfunction

    function automatic near_point_t project_point(query_t q);
        longint      dx;
        longint      dy;
        longint      num;
        longint      den;
        logic        ovf;
        near_point_t r;
        dx  = longint'(q.ex) - longint'(q.sx);
        dy  = longint'(q.ey) - longint'(q.sy);
        num = (longint'(q.qx) - longint'(q.sx)) * dx + (longint'(q.qy) - longint'(q.sy)) * dy;
        den = dx * dx + dy * dy;
        ovf = 1'b0;
        if (den == 0) begin
            r = '{q.sx, q.sy, ST_DEGEN};
        end else if (q.clamp && num <= 0) begin
            r = '{q.sx, q.sy, ST_CLAMP};
        end else if (q.clamp && num > den) begin
            r = '{q.ex, q.ey, ST_CLAMP};
        end else begin
            r.near_x = clip_coord(longint'(q.sx) + share_of(dx, num, den), ovf);
            r.near_y = clip_coord(longint'(q.sy) + share_of(dy, num, den), ovf);
            r.status = ovf ? ST_SAT : ST_OK;
        end
        return r;
    endfunction

    function automatic query_t mk(int sx, int sy, int ex, int ey, int qx, int qy, bit clamp);
        query_t q;
        q = '{coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey),
              coord_t'(qx), coord_t'(qy), clamp};
        return q;
    endfunction

    function automatic int any_coord();
        return int'(coord_t'($urandom));
    endfunction

    function automatic int jitter(int c, int span);
        return c + int'($urandom_range(2 * span)) - span;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                near_point_q.push_back(project_point(mk(s_start_x, s_start_y, s_end_x,
                    s_end_y, s_query_x, s_query_y, s_clamp_to_segment)));
                beats_in <= beats_in + 1;
            end
            if (!s_valid || s_ready) begin
                if (query_q.size() != 0 &&
                    ((beats_in >= 700 && beats_in < 1000) || $urandom_range(99) >= 27)) begin
                    next_query = query_q.pop_front();
                    s_start_x          <= next_query.sx;
                    s_start_y          <= next_query.sy;
                    s_end_x            <= next_query.ex;
                    s_end_y            <= next_query.ey;
                    s_query_x          <= next_query.qx;
                    s_query_y          <= next_query.qy;
                    s_clamp_to_segment <= next_query.clamp;
                    s_valid            <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (near_point_q.size() == 0) begin
                    $error("result beat with nothing expected: x %0d y %0d status %0d",
                           m_near_x, m_near_y, m_status);
                    mismatches = mismatches + 1;
                end else begin
                    want = near_point_q.pop_front();
                    if (m_near_x !== want.near_x) begin
                        $error("near_x: expected %0d, got %0d", want.near_x, m_near_x);
                        mismatches = mismatches + 1;
                    end
                    if (m_near_y !== want.near_y) begin
                        $error("near_y: expected %0d, got %0d", want.near_y, m_near_y);
                        mismatches = mismatches + 1;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        mismatches = mismatches + 1;
                    end
                end
                beats_out <= beats_out + 1;
            end
            m_ready <= (beats_out >= 700 && beats_out < 1000) || $urandom_range(99) >= 27;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("closest_point_on_segment: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int kind;
        int sx;
        int sy;
        int ex;
        int ey;
        int qx;
        int qy;
        bit clamp;

        // degenerate segments
        query_q.push_back(mk(100, -200, 100, -200, 5, 5, 1'b0));
        query_q.push_back(mk(-32768, 32767, -32768, 32767, 32767, -32768, 1'b1));
        // before the start, on the start's normal, past the end, exactly at the end
        query_q.push_back(mk(0, 0, 256, 0, -512, 100, 1'b1));
        query_q.push_back(mk(0, 0, 256, 0, 0, 300, 1'b1));
        query_q.push_back(mk(0, 0, 256, 0, 1000, 5, 1'b1));
        query_q.push_back(mk(0, 0, 256, 0, 256, 77, 1'b1));
        query_q.push_back(mk(0, 0, 256, 0, -512, 100, 1'b0));
        query_q.push_back(mk(0, 0, 256, 0, 1000, 5, 1'b0));
        // saturation high and low
        query_q.push_back(mk(0, 0, 1, 2, 32767, 32767, 1'b0));
        query_q.push_back(mk(0, 0, 1, 2, -32768, -32768, 1'b0));
        query_q.push_back(mk(0, 0, 2, 1, 32767, 32767, 1'b0));
        // rounding ties
        query_q.push_back(mk(0, 0, 1, 1, 1, 0, 1'b0));
        query_q.push_back(mk(0, 0, 1, 1, -1, 0, 1'b0));
        query_q.push_back(mk(0, 0, 1, 1, 1, 0, 1'b1));
        // full-scale extremes
        query_q.push_back(mk(-32768, -32768, 32767, 32767, 32767, -32768, 1'b0));
        query_q.push_back(mk(-32768, -32768, 32767, 32767, 32767, -32768, 1'b1));
        query_q.push_back(mk(32767, -32768, -32768, 32767, -32768, -32768, 1'b1));
        query_q.push_back(mk(-32768, -32768, 32767, 32767, 32767, 32767, 1'b0));
        query_q.push_back(mk(-32768, -32768, 32767, 32767, 32767, 32767, 1'b1));
        query_q.push_back(mk(32767, 32767, -32768, -32768, -32768, 32767, 1'b0));

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            kind  = $urandom_range(99);
            clamp = $urandom_range(1);
            sx = any_coord();
            sy = any_coord();
            ex = any_coord();
            ey = any_coord();
            qx = any_coord();
            qy = any_coord();
            if (kind < 35) begin
                // full range
            end else if (kind < 60) begin
                // small coordinates, ties and clamps are frequent
                sx = jitter(0, 64);
                sy = jitter(0, 64);
                ex = jitter(0, 64);
                ey = jitter(0, 64);
                qx = jitter(0, 96);
                qy = jitter(0, 96);
            end else if (kind < 75) begin
                // query close to one endpoint
                if ($urandom_range(1)) begin
                    qx = jitter(sx, 8);
                    qy = jitter(sy, 8);
                end else begin
                    qx = jitter(ex, 8);
                    qy = jitter(ey, 8);
                end
            end else if (kind < 82) begin
                ex = sx;
                ey = sy;
            end else if (kind < 90) begin
                // axis-aligned or very short segment
                case ($urandom_range(2))
                    0: ey = sy;
                    1: ex = sx;
                    default: begin
                        ex = jitter(sx, 2);
                        ey = jitter(sy, 2);
                    end
                endcase
            end else begin
                // query on the line: at the end or on its extension
                qx = ex;
                qy = ey;
                if ($urandom_range(1)) begin
                    qx = 2 * ex - sx;
                    qy = 2 * ey - sy;
                end
            end
            query_q.push_back(mk(sx, sy, ex, ey, qx, qy, clamp));
        end

        @(posedge aclk);
        while (query_q.size() != 0 || s_valid || near_point_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("closest_point_on_segment: match");
        else
            $display("closest_point_on_segment: mismatch");
        $finish;
    end

endmodule
